### rtl/torus_walker_pixel_update_macros.svh
// Assertion macros shared by the checker files.
`ifndef TORUS_WALKER_PIXEL_UPDATE_MACROS_SVH
`define TORUS_WALKER_PIXEL_UPDATE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define TWPU_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TWPU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent checked later than the antecedent, after a delay.
`define TWPU_ASSERT_LATER2(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error(msg);

`endif

### rtl/twpu_pkg.sv
// Types and constants of the torus walker pixel update block.
package twpu_pkg;

    localparam int POS_W      = 16;
    localparam int POS_SPAN   = 65536;
    localparam int CFG_W      = 17;
    localparam int CFG_IDX_W  = 1;
    localparam int MODE_W     = 3;
    localparam int SEL_W      = 3;
    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int ACC_W      = 18;
    localparam int CNT_W      = 4;

    localparam logic [CNT_W-1:0] BIT_LAST = CNT_W'(POS_W - 1);
    localparam logic [CH_W-1:0]  CH_MAX   = 8'hFF;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT = 1'b1;

    localparam logic [CFG_W-1:0] GRID_WIDTH_RST  = 17'd256;
    localparam logic [CFG_W-1:0] PIXEL_COUNT_RST = 17'd65536;

    localparam logic [MODE_W-1:0] MODE_UP    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DOWN  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LEFT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RIGHT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PLACE = 3'd4;
    localparam logic [MODE_W-1:0] MODE_READ  = 3'd5;

    localparam logic [1:0] CHAN_RED   = 2'd0;
    localparam logic [1:0] CHAN_GREEN = 2'd1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EFF,
        ST_CHK,
        ST_FIX,
        ST_MOD,
        ST_STEP1,
        ST_STEP2,
        ST_REDUCE,
        ST_RD,
        ST_PIX,
        ST_DONE
    } state_t;

endpackage

### rtl/twpu_if.sv
// Item channel interfaces: command items in, result items out.
interface twpu_cmd_if import twpu_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [SEL_W-1:0]  walker_sel;
    logic [POS_W-1:0]  position;

    modport source (output valid, output mode, output walker_sel, output position,
                    input ready);
    modport sink   (input valid, input mode, input walker_sel, input position,
                    output ready);
endinterface

interface twpu_rsp_if import twpu_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] new_position;
    logic [CH_W-1:0]  red_value;
    logic [CH_W-1:0]  green_value;
    logic [CH_W-1:0]  blue_value;
    logic             range_error;

    modport source (output valid, output new_position, output red_value,
                    output green_value, output blue_value, output range_error,
                    input ready);
    modport sink   (input valid, input new_position, input red_value,
                    input green_value, input blue_value, input range_error,
                    output ready);
endinterface

### rtl/torus_walker_pixel_update.sv
// One item at a time; a held result stalls the sequencer. Left/right moves first run
// a remainder loop over the position bits.
// Reset: async active low; walkers go to 0, registers to width 256 and count 65536.
// After reset a clearing pass writes zero to every pixel, with cmd.ready low;
// configuration writes are taken during the pass.
module torus_walker_pixel_update import twpu_pkg::*; #(
    parameter int MAX_PIXELS  = 65536,
    parameter int NUM_WALKERS = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    twpu_cmd_if.sink             cmd,
    twpu_rsp_if.source           rsp
);

    localparam int MEM_DEPTH = (MAX_PIXELS < POS_SPAN) ? MAX_PIXELS : POS_SPAN;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam logic [CFG_W-1:0]  CAP       = CFG_W'(MEM_DEPTH);
    localparam logic [ADDR_W-1:0] CLR_LAST  = ADDR_W'(MEM_DEPTH - 1);
    localparam logic [SEL_W-1:0]  NW_LIMIT  = SEL_W'(NUM_WALKERS);

    state_t             state_reg, state_next;
    logic [CFG_W-1:0]   gw_reg, pc_reg;
    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [SEL_W-1:0]   sel_reg, sel_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [CFG_W-1:0]   n_reg, n_next;
    logic [CFG_W-1:0]   w_reg, w_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [CFG_W-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [POS_W-1:0]   res_pos_reg, res_pos_next;
    logic [PIX_W-1:0]   res_pix_reg, res_pix_next;
    logic               res_err_reg, res_err_next;
    logic [POS_W-1:0]   out_pos_reg;
    logic [PIX_W-1:0]   out_pix_reg;
    logic               out_err_reg;
    logic               out_valid_reg, out_valid_next;
    logic               out_load;
    logic [ADDR_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [POS_W-1:0]   wpos_reg [NUM_WALKERS];
    logic               wpos_we;
    logic [POS_W-1:0]   wpos_wdata;
    logic [POS_W-1:0]   wpos_sel;

    logic [PIX_W-1:0]   pix_mem [MEM_DEPTH];
    logic [PIX_W-1:0]   mem_rdata_reg;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [PIX_W-1:0]   mem_wdata;
    logic [ADDR_W-1:0]  mem_raddr;

    logic [ACC_W-1:0]   alu_a, alu_b, alu_b_eff, alu_sum;
    logic               alu_sub, alu_carry;

    logic [CFG_W-1:0]   n_eff, w_eff;
    logic               sel_ok;
    logic [POS_W-1:0]   p_cur;
    logic               pbit;
    logic               rem_last;
    logic [CH_W-1:0]    cur_ch, new_ch;
    logic [PIX_W-1:0]   new_pix;

    // shared add/subtract unit; carry high on subtract means a >= b
    always_comb
    begin
        alu_b_eff = alu_sub ? ~alu_b : alu_b;
        {alu_carry, alu_sum} = {1'b0, alu_a} + {1'b0, alu_b_eff} + (ACC_W + 1)'(alu_sub);
    end

    always_comb
    begin
        if (pc_reg == '0)
            n_eff = CFG_W'(1);
        else if (pc_reg > CAP)
            n_eff = CAP;
        else
            n_eff = pc_reg;
    end

    always_comb
    begin
        if (gw_reg == '0)
            w_eff = CFG_W'(1);
        else if (gw_reg > n_reg)
            w_eff = n_reg;
        else
            w_eff = gw_reg;
    end

    always_comb
    begin
        wpos_sel = '0;
        for (int i = 0; i < NUM_WALKERS; i++)
        begin
            if (sel_reg == SEL_W'(i))
                wpos_sel = wpos_reg[i];
        end
    end

    assign sel_ok    = sel_reg < NW_LIMIT;
    assign p_cur     = acc_reg[POS_W-1:0];
    assign pbit      = p_cur[bit_cnt_reg];
    assign rem_last  = ({1'b0, rem_reg} + ACC_W'(1)) == {1'b0, w_reg};
    assign mem_raddr = acc_reg[ADDR_W-1:0];

    // saturating nudge of the walker's channel: even walkers count down, odd up
    always_comb
    begin
        case (sel_reg[2:1])
            CHAN_RED:   cur_ch = mem_rdata_reg[23:16];
            CHAN_GREEN: cur_ch = mem_rdata_reg[15:8];
            default:    cur_ch = mem_rdata_reg[7:0];
        endcase
        if (sel_reg[0])
            new_ch = (cur_ch == CH_MAX) ? cur_ch : cur_ch + CH_W'(1);
        else
            new_ch = (cur_ch == '0) ? cur_ch : cur_ch - CH_W'(1);
        case (sel_reg[2:1])
            CHAN_RED:   new_pix = {new_ch, mem_rdata_reg[15:0]};
            CHAN_GREEN: new_pix = {mem_rdata_reg[23:16], new_ch, mem_rdata_reg[7:0]};
            default:    new_pix = {mem_rdata_reg[23:8], new_ch};
        endcase
    end

    assign cmd.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        sel_next     = sel_reg;
        pos_next     = pos_reg;
        n_next       = n_reg;
        w_next       = w_reg;
        acc_next     = acc_reg;
        rem_next     = rem_reg;
        bit_cnt_next = bit_cnt_reg;
        res_pos_next = res_pos_reg;
        res_pix_next = res_pix_reg;
        res_err_next = res_err_reg;
        clr_cnt_next = clr_cnt_reg;
        out_load     = 1'b0;
        wpos_we      = 1'b0;
        wpos_wdata   = acc_reg[POS_W-1:0];
        mem_we       = 1'b0;
        mem_waddr    = acc_reg[ADDR_W-1:0];
        mem_wdata    = new_pix;
        alu_a        = acc_reg;
        alu_b        = {1'b0, n_reg};
        alu_sub      = 1'b1;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
                if (clr_cnt_reg == CLR_LAST)
                    state_next = ST_IDLE;
                else
                    clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
            end
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    mode_next  = cmd.mode;
                    sel_next   = cmd.walker_sel;
                    pos_next   = cmd.position;
                    n_next     = n_eff;
                    state_next = ST_EFF;
                end
            end
            ST_EFF:
            begin
                w_next       = w_eff;
                res_pos_next = '0;
                res_pix_next = '0;
                res_err_next = 1'b0;
                case (mode_reg)
                    MODE_UP, MODE_DOWN, MODE_LEFT, MODE_RIGHT:
                    begin
                        acc_next   = {2'b00, wpos_sel};
                        state_next = sel_ok ? ST_FIX : ST_DONE;
                    end
                    MODE_PLACE: state_next = sel_ok ? ST_CHK : ST_DONE;
                    MODE_READ:  state_next = ST_CHK;
                    default:    state_next = ST_DONE;
                endcase
            end
            ST_CHK:
            begin
                alu_a = {2'b00, pos_reg};
                if (alu_carry)
                begin
                    res_err_next = 1'b1;
                    if (mode_reg == MODE_READ)
                    begin
                        res_pos_next = pos_reg;
                        res_pix_next = '0;
                        state_next   = ST_DONE;
                    end
                    else
                    begin
                        // place out of range: report the walker where it stands
                        acc_next   = {2'b00, wpos_sel};
                        state_next = ST_RD;
                    end
                end
                else
                begin
                    acc_next   = {2'b00, pos_reg};
                    wpos_we    = (mode_reg == MODE_PLACE);
                    wpos_wdata = pos_reg;
                    state_next = ST_RD;
                end
            end
            ST_FIX:
            begin
                // a walker left off the grid by a smaller count restarts at 0
                if (alu_carry)
                    acc_next = '0;
                rem_next     = '0;
                bit_cnt_next = BIT_LAST;
                if (mode_reg == MODE_LEFT || mode_reg == MODE_RIGHT)
                    state_next = ST_MOD;
                else
                    state_next = ST_STEP1;
            end
            ST_MOD:
            begin
                // restoring remainder, one position bit per cycle
                alu_a    = {rem_reg, pbit};
                alu_b    = {1'b0, w_reg};
                rem_next = alu_carry ? alu_sum[CFG_W-1:0] : alu_a[CFG_W-1:0];
                if (bit_cnt_reg == '0)
                    state_next = ST_STEP1;
                else
                    bit_cnt_next = bit_cnt_reg - CNT_W'(1);
            end
            ST_STEP1:
            begin
                acc_next = alu_sum;
                case (mode_reg)
                    MODE_UP:
                    begin
                        alu_b      = {1'b0, w_reg};
                        state_next = alu_carry ? ST_REDUCE : ST_STEP2;
                    end
                    MODE_DOWN:
                    begin
                        alu_b      = {1'b0, w_reg};
                        alu_sub    = 1'b0;
                        state_next = ST_REDUCE;
                    end
                    MODE_LEFT:
                    begin
                        if (rem_reg == '0)
                        begin
                            alu_b      = {1'b0, w_reg};
                            alu_sub    = 1'b0;
                            state_next = ST_STEP2;
                        end
                        else
                        begin
                            alu_b      = ACC_W'(1);
                            state_next = ST_REDUCE;
                        end
                    end
                    default:
                    begin
                        alu_b      = ACC_W'(1);
                        alu_sub    = 1'b0;
                        state_next = rem_last ? ST_STEP2 : ST_REDUCE;
                    end
                endcase
            end
            ST_STEP2:
            begin
                acc_next   = alu_sum;
                state_next = ST_REDUCE;
                case (mode_reg)
                    MODE_UP:   alu_sub = 1'b0;
                    MODE_LEFT: alu_b   = ACC_W'(1);
                    default:   alu_b   = {1'b0, w_reg};
                endcase
            end
            ST_REDUCE:
            begin
                // fold back into the grid; also covers a partial last row
                if (alu_carry)
                    acc_next = alu_sum;
                wpos_we      = 1'b1;
                wpos_wdata   = alu_carry ? alu_sum[POS_W-1:0] : acc_reg[POS_W-1:0];
                res_err_next = 1'b0;
                state_next   = ST_RD;
            end
            ST_RD:
            begin
                state_next = ST_PIX;
            end
            ST_PIX:
            begin
                res_pos_next = acc_reg[POS_W-1:0];
                if (mode_reg != MODE_PLACE && mode_reg != MODE_READ)
                begin
                    mem_we       = 1'b1;
                    res_pix_next = new_pix;
                end
                else
                    res_pix_next = mem_rdata_reg;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
            clr_cnt_reg   <= '0;
            gw_reg        <= GRID_WIDTH_RST;
            pc_reg        <= PIXEL_COUNT_RST;
            for (int i = 0; i < NUM_WALKERS; i++)
                wpos_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            clr_cnt_reg   <= clr_cnt_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_GRID_WIDTH:  gw_reg <= cfg_wdata;
                    CFG_PIXEL_COUNT: pc_reg <= cfg_wdata;
                    default:         ;
                endcase
            end
            for (int i = 0; i < NUM_WALKERS; i++)
            begin
                if (wpos_we && sel_reg == SEL_W'(i))
                    wpos_reg[i] <= wpos_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        sel_reg     <= sel_next;
        pos_reg     <= pos_next;
        n_reg       <= n_next;
        w_reg       <= w_next;
        acc_reg     <= acc_next;
        rem_reg     <= rem_next;
        bit_cnt_reg <= bit_cnt_next;
        res_pos_reg <= res_pos_next;
        res_pix_reg <= res_pix_next;
        res_err_reg <= res_err_next;
        if (out_load)
        begin
            out_pos_reg <= res_pos_reg;
            out_pix_reg <= res_pix_reg;
            out_err_reg <= res_err_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            pix_mem[mem_waddr] <= mem_wdata;
        mem_rdata_reg <= pix_mem[mem_raddr];
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.new_position = out_pos_reg;
    assign rsp.red_value    = out_pix_reg[23:16];
    assign rsp.green_value  = out_pix_reg[15:8];
    assign rsp.blue_value   = out_pix_reg[7:0];
    assign rsp.range_error  = out_err_reg;

endmodule

### rtl/twpu_checker.sv
// Port-level checks for the torus walker pixel update block, bound to the top level.
`include "torus_walker_pixel_update_macros.svh"

module twpu_checker import twpu_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             cmd_valid,
    input logic             cmd_ready,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input logic [POS_W-1:0] new_position,
    input logic [CH_W-1:0]  red_value,
    input logic [CH_W-1:0]  green_value,
    input logic [CH_W-1:0]  blue_value,
    input logic             range_error
);

    // one item in flight: the block goes busy right after taking an item
    `TWPU_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, cmd_valid && cmd_ready, !cmd_ready, "ready high right after an accepted item")

    // every item passes ST_EFF and a further sequencer state before ready returns
    `TWPU_ASSERT_LATER2(a_min_latency, clk, rst_n, cmd_valid && cmd_ready, !cmd_ready, "ready back too early after an item")

    `TWPU_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")

    `TWPU_ASSERT_NEXT(a_rsp_stable, clk, rst_n, rsp_valid && !rsp_ready, $stable({new_position, red_value, green_value, blue_value, range_error}), "result changed while stalled")

endmodule

bind torus_walker_pixel_update twpu_checker u_twpu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd.valid),
    .cmd_ready    (cmd.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .new_position (rsp.new_position),
    .red_value    (rsp.red_value),
    .green_value  (rsp.green_value),
    .blue_value   (rsp.blue_value),
    .range_error  (rsp.range_error)
);

### verif/tb.sv
// Testbench for the torus walker pixel update block: self-predicting driver and result monitor.
module tb;
    import twpu_pkg::*;

    localparam int NUM_WALK     = 6;
    localparam int MAX_PIX      = 65536;
    localparam int IDLE_PCT     = 22;
    localparam int SETTLE_GAP   = 40;
    localparam int STALL_LIMIT  = 200000;

    // modes with no defined action
    localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SEL_W-1:0]  sel;
        logic [POS_W-1:0]  pos;
    } walker_cmd_t;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic             range_err;
    } pixel_report_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_wdata;

    twpu_cmd_if cmd_ch ();
    twpu_rsp_if rsp_ch ();

    torus_walker_pixel_update u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch)
    );

    // shadow of the block's state
    logic [CFG_W-1:0] grid_width_q;
    logic [CFG_W-1:0] pixel_count_q;
    logic [POS_W-1:0] walker_at [0:NUM_WALK-1];
    logic [PIX_W-1:0] pixel_mem [0:MAX_PIX-1];

    walker_cmd_t   cmds_waiting [$];
    pixel_report_t reports_due [$];
    pixel_report_t due;
    bit calm;
    bit hold_cmds;
    int fails;
    int stall_cycles;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int unsigned active_pixels();
        int unsigned n;
        n = pixel_count_q;
        if (n == 0) n = 1;
        if (n > MAX_PIX) n = MAX_PIX;
        return n;
    endfunction

    function automatic pixel_report_t report(input int unsigned pos, input logic [PIX_W-1:0] px,
                                             input logic err);
        return '{POS_W'(pos), px[23:16], px[15:8], px[7:0], err};
    endfunction

    // apply one item to the shadow state and return the result it must produce
    function automatic pixel_report_t walk_and_paint(input walker_cmd_t c);
        int unsigned n;
        int unsigned w;
        int unsigned p;
        int unsigned r;
        int hi;
        logic [PIX_W-1:0] px;
        n = active_pixels();
        w = (grid_width_q == 0) ? 1 : grid_width_q;
        if (w > n) w = n;
        if (c.mode <= MODE_RIGHT) begin
            if (c.sel >= NUM_WALK) return '0;
            p = walker_at[c.sel];
            if (p >= n) p = 0;
            case (c.mode)
                MODE_UP:   r = (p >= w) ? p - w : p + n - w;
                MODE_DOWN: r = (p < n - w) ? p + w : p + w - n;
                MODE_LEFT: r = ((p % w) == 0) ? p + w - 1 : p - 1;
                default:   r = ((p % w) == w - 1) ? p + 1 - w : p + 1;
            endcase
            if (r >= n) r -= n;
            walker_at[c.sel] = POS_W'(r);
            px = pixel_mem[r];
            hi = 23 - 8 * (c.sel / 2);
            // odd walkers brighten their channel, even ones darken it
            if (c.sel[0]) begin
                if (px[hi -: 8] != CH_MAX) px[hi -: 8] = px[hi -: 8] + 8'd1;
            end
            else if (px[hi -: 8] != 8'd0) begin
                px[hi -: 8] = px[hi -: 8] - 8'd1;
            end
            pixel_mem[r] = px;
            return report(r, px, 1'b0);
        end
        if (c.mode == MODE_PLACE) begin
            if (c.sel >= NUM_WALK) return '0;
            if (c.pos >= n) begin
                p = walker_at[c.sel];
                return report(p, pixel_mem[p], 1'b1);
            end
            walker_at[c.sel] = c.pos;
            return report(c.pos, pixel_mem[c.pos], 1'b0);
        end
        if (c.mode == MODE_READ) begin
            if (c.pos >= n) return report(c.pos, '0, 1'b1);
            return report(c.pos, pixel_mem[c.pos], 1'b0);
        end
        return '0;
    endfunction

    task automatic add_cmd(input logic [MODE_W-1:0] md, input int sel, input int pos);
        cmds_waiting.push_back('{md, SEL_W'(sel), POS_W'(pos)});
    endtask

    task automatic settle();
        while (cmds_waiting.size() != 0 || reports_due.size() != 0 || cmd_ch.valid)
            @(negedge clk);
        repeat (SETTLE_GAP) @(negedge clk);
    endtask

    task automatic set_grid(input int w, input int c);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_GRID_WIDTH;
        cfg_wdata <= CFG_W'(w);
        @(posedge clk);
        cfg_index <= CFG_PIXEL_COUNT;
        cfg_wdata <= CFG_W'(c);
        @(posedge clk);
        cfg_we <= 1'b0;
        grid_width_q  = CFG_W'(w);
        pixel_count_q = CFG_W'(c);
        @(negedge clk);
    endtask

    // mostly moves, then places, reads near walkers, and a share of junk items;
    // focus mode keeps stepping walker 1, which brightens its red channel
    task automatic gen_items(input int count, input bit focus);
        int roll;
        int n;
        logic [MODE_W-1:0] md;
        int sel;
        int pos;
        n = active_pixels();
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(99);
            pos  = $urandom_range(16'hFFFF);
            sel  = $urandom_range(NUM_WALK - 1);
            md   = MODE_W'($urandom_range(3));
            if (focus && roll < 75) begin
                sel = 1;
            end
            else if (roll < 60) begin
                if ($urandom_range(19) == 0) sel = $urandom_range(7);
            end
            else if (roll < 75) begin
                md = MODE_PLACE;
                if ($urandom_range(4) != 0) pos = $urandom_range(n - 1);
            end
            else if (roll < 90) begin
                md = MODE_READ;
                if ($urandom_range(1) == 1) pos = walker_at[$urandom_range(NUM_WALK - 1)];
                else if ($urandom_range(3) != 0) pos = $urandom_range(n - 1);
            end
            else begin
                md  = MODE_W'($urandom_range(7));
                sel = $urandom_range(7);
            end
            add_cmd(md, sel, pos);
        end
    endtask

    task automatic run_phase(input int w, input int c, input int count, input bit focus);
        settle();
        set_grid(w, c);
        gen_items(count, focus);
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            fails++;
        end
    endtask

    // command driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cmd_ch.valid <= 1'b0;
        end
        else begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                reports_due.push_back(walk_and_paint(cmds_waiting[0]));
                void'(cmds_waiting.pop_front());
            end
            if (!(cmd_ch.valid && !cmd_ch.ready)) begin
                if (cmds_waiting.size() != 0 && !hold_cmds &&
                    (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    cmd_ch.valid      <= 1'b1;
                    cmd_ch.mode       <= cmds_waiting[0].mode;
                    cmd_ch.walker_sel <= cmds_waiting[0].sel;
                    cmd_ch.position   <= cmds_waiting[0].pos;
                end
                else begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
        end
        else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (reports_due.size() == 0) begin
                    $error("result item with nothing expected, new_position %0d",
                           rsp_ch.new_position);
                    fails++;
                end
                else begin
                    due = reports_due.pop_front();
                    check_field("new_position", due.position, rsp_ch.new_position);
                    check_field("red_value", due.red, rsp_ch.red_value);
                    check_field("green_value", due.green, rsp_ch.green_value);
                    check_field("blue_value", due.blue, rsp_ch.blue_value);
                    check_field("range_error", due.range_err, rsp_ch.range_error);
                end
            end
            rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ends the run when no item moves for too long (covers the clearing pass)
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
        else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_GRID_WIDTH;
        cfg_wdata         = '0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.mode       = MODE_UP;
        cmd_ch.walker_sel = '0;
        cmd_ch.position   = '0;
        rsp_ch.ready      = 1'b0;
        calm              = 1'b0;
        hold_cmds         = 1'b0;
        fails             = 0;
        stall_cycles      = 0;
        grid_width_q      = GRID_WIDTH_RST;
        pixel_count_q     = PIXEL_COUNT_RST;
        for (int i = 0; i < NUM_WALK; i++) walker_at[i] = '0;
        for (int i = 0; i < MAX_PIX; i++) pixel_mem[i] = '0;
        repeat (9) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // 10 wide, 25 pixels: last row is partial
        set_grid(10, 25);
        add_cmd(MODE_UP, 0, 0);          // wraps to 15, red stays at zero
        add_cmd(MODE_DOWN, 1, 0);
        add_cmd(MODE_LEFT, 2, 0);        // wraps to end of row
        add_cmd(MODE_RIGHT, 3, 0);
        add_cmd(MODE_PLACE, 4, 24);
        add_cmd(MODE_RIGHT, 4, 0);       // lands past the count
        add_cmd(MODE_PLACE, 5, 20);
        add_cmd(MODE_LEFT, 5, 0);        // row wrap from the partial row, folded back to 4
        add_cmd(MODE_DOWN, 5, 0);
        add_cmd(MODE_DOWN, 5, 0);
        add_cmd(MODE_DOWN, 5, 0);        // wraps to top
        add_cmd(MODE_UP, 3, 0);
        add_cmd(MODE_PLACE, 0, 16'hFFFF);
        add_cmd(MODE_PLACE, 1, 25);      // first index out of range
        add_cmd(MODE_READ, 0, 16'hFFFF);
        add_cmd(MODE_READ, 2, 10);
        add_cmd(MODE_READ, 0, 0);
        add_cmd(MODE_UP, NUM_WALK, 0);
        add_cmd(MODE_PLACE, NUM_WALK + 1, 3);
        add_cmd(MODE_SPARE_A, 0, 16'hAAAA);
        add_cmd(MODE_SPARE_B, 5, 16'h5555);
        add_cmd(MODE_READ, 7, 24);
        add_cmd(MODE_PLACE, 2, 24);      // left off grid by the next setting
        add_cmd(MODE_RIGHT, 1, 16'hFFFF);

        // single pixel: every walker but walker 4 off grid, walker 1 brightens red
        run_phase(1, 1, 300, 1'b1);
        run_phase(0, 0, 20, 1'b0);
        run_phase(131071, 131071, 80, 1'b0);

        calm = 1'b1;
        run_phase(256, 65536, 100, 1'b0);
        settle();
        calm = 1'b0;

        run_phase(7, 40, 150, 1'b0);
        while (cmds_waiting.size() > 75) @(negedge clk);
        hold_cmds = 1'b1;
        while (reports_due.size() != 0 || cmd_ch.valid) @(negedge clk);
        hold_cmds = 1'b0;

        run_phase(3, 12, 150, 1'b0);
        run_phase(65536, 65535, 30, 1'b0);
        run_phase(1, 65536, 30, 1'b0);
        settle();

        if (fails == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
